>>> design/length_prefixed_message_deframer_top_macros.svh
// Assertion macros shared by the deframer RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks away.
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_TOP_MACROS_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that cons holds in every cycle in which ante holds.
`define LPMD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpmd: implication check failed");

// Check that cond holds in every cycle out of reset.
`define LPMD_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("lpmd: invariant check failed");

`else

`define LPMD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LPMD_ASSERT_ALWAYS(label, clk, rst, cond)

`endif

`endif

>>> design/lpmd_pkg.sv
// Shared types and constants for the length-prefixed message deframer.
// Depends on nothing; imported by lpmd_parse and the top level.
`timescale 1ns / 1ps

package lpmd_pkg;

   // Last header byte position and the width of the header byte counter.
   localparam int HdrCntW = 4;
   localparam logic [HdrCntW-1:0] HDR_LAST = 4'd11;

   // First header byte position after each field.
   localparam logic [HdrCntW-1:0] HDR_TYPE_END    = 4'd2;
   localparam logic [HdrCntW-1:0] HDR_COMMAND_END = 4'd4;
   localparam logic [HdrCntW-1:0] HDR_INDEX_END   = 4'd6;
   localparam logic [HdrCntW-1:0] HDR_TOTAL_END   = 4'd8;

   localparam int TDATA_W = 104;

   typedef struct packed {
      logic        last;
      logic        byte_valid;
      logic [7:0]  payload_byte;
      logic [31:0] payload_length;
      logic [15:0] part_total;
      logic [15:0] part_index;
      logic [15:0] command;
      logic [15:0] msg_type;
   } result_type;

endpackage

>>> design/lpmd_parse.sv
// Header capture and payload tracking for one byte per cycle while advance is high.
// Depends on lpmd_pkg; assertions use the shared macro header.
`timescale 1ns / 1ps
`include "length_prefixed_message_deframer_top_macros.svh"

module lpmd_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [7:0]           data_byte,
   output logic                 res_valid,
   output lpmd_pkg::result_type result
);
   import lpmd_pkg::*;

   logic               in_payload_ff, in_payload_in;
   logic [HdrCntW-1:0] header_count_ff, header_count_in;
   logic [15:0]        type_ff, type_in;
   logic [15:0]        command_ff, command_in;
   logic [15:0]        index_ff, index_in;
   logic [15:0]        total_ff, total_in;
   logic [31:0]        length_ff, length_in;
   logic [31:0]        remaining_ff, remaining_in;
   logic               final_byte;

   assign final_byte = (remaining_ff <= 32'd1);

   always_comb begin
      in_payload_in   = in_payload_ff;
      header_count_in = header_count_ff;
      type_in         = type_ff;
      command_in      = command_ff;
      index_in        = index_ff;
      total_in        = total_ff;
      length_in       = length_ff;
      remaining_in    = remaining_ff;
      res_valid       = 1'b0;

      if (in_payload_ff) begin
         res_valid = 1'b1;
         if (final_byte) begin
            remaining_in    = '0;
            in_payload_in   = 1'b0;
            header_count_in = '0;
         end else begin
            remaining_in = remaining_ff - 32'd1;
         end
      end else begin
         // shift the byte into whichever field the count points at
         if (header_count_ff < HDR_TYPE_END) begin
            type_in = {type_ff[7:0], data_byte};
         end else if (header_count_ff < HDR_COMMAND_END) begin
            command_in = {command_ff[7:0], data_byte};
         end else if (header_count_ff < HDR_INDEX_END) begin
            index_in = {index_ff[7:0], data_byte};
         end else if (header_count_ff < HDR_TOTAL_END) begin
            total_in = {total_ff[7:0], data_byte};
         end else begin
            length_in = {length_ff[23:0], data_byte};
         end

         if (header_count_ff == HDR_LAST) begin
            header_count_in = '0;
            if (length_in == 32'd0) begin
               res_valid = 1'b1;
            end else begin
               in_payload_in = 1'b1;
               remaining_in  = length_in;
            end
         end else begin
            header_count_in = header_count_ff + HdrCntW'(1);
         end
      end
   end

   // Result carries the header as it stands after this byte.
   always_comb begin
      result.msg_type       = type_in;
      result.command        = command_in;
      result.part_index     = index_in;
      result.part_total     = total_in;
      result.payload_length = length_in;
      result.payload_byte   = in_payload_ff ? data_byte : 8'd0;
      result.byte_valid     = in_payload_ff;
      result.last           = in_payload_ff ? final_byte : 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff   <= 1'b0;
         header_count_ff <= '0;
         type_ff         <= '0;
         command_ff      <= '0;
         index_ff        <= '0;
         total_ff        <= '0;
         length_ff       <= '0;
         remaining_ff    <= '0;
      end else if (advance) begin
         in_payload_ff   <= in_payload_in;
         header_count_ff <= header_count_in;
         type_ff         <= type_in;
         command_ff      <= command_in;
         index_ff        <= index_in;
         total_ff        <= total_in;
         length_ff       <= length_in;
         remaining_ff    <= remaining_in;
      end
   end

   `LPMD_ASSERT_IMPLY(a_payload_count_live, clock, reset, in_payload_ff, remaining_ff != 32'd0)
   `LPMD_ASSERT_IMPLY(a_header_count_range, clock, reset, !in_payload_ff, header_count_ff <= HDR_LAST)
   `LPMD_ASSERT_IMPLY(a_count_idle_in_payload, clock, reset, in_payload_ff, header_count_ff == '0)

endmodule

>>> design/length_prefixed_message_deframer_top.sv
// Path: an accepted byte waits in the input register, the parse stage turns it into
// a word where one is due, and that word enters the result queue that drives rsp_.
// Throughput: one byte per cycle, set by the single parse stage between the
// input register and a two-word result queue; rsp_tready low only stalls req_
// once the queue is full and the input register holds a byte.
// Reset: synchronous, returns to header capture with all header fields zero.
`timescale 1ns / 1ps
`include "length_prefixed_message_deframer_top_macros.svh"

module length_prefixed_message_deframer_top (
   input  logic                        clock,
   input  logic                        reset,
   // request stream: one raw byte per word
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] data_byte
   // result stream
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [15:0] msg_type, [31:16] command, [47:32] part_index, [63:48] part_total,
   // [95:64] payload_length, [103:96] payload_byte
   output logic [lpmd_pkg::TDATA_W-1:0] rsp_tdata,
   output logic                        rsp_tuser,   // [0] byte_valid
   output logic                        rsp_tlast    // last word of a message
);
   import lpmd_pkg::*;

   // Input register: hold one byte until the parse stage takes it.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // Result queue: q0 is the head, q1 the second word.
   logic [1:0] count_ff, count_in;
   result_type q0_ff, q0_in;
   result_type q1_ff, q1_in;

   logic       advance;
   logic       res_valid;
   result_type result;
   logic       push;
   logic       pop;
   logic       req_fire;
   logic       empty_word_ok;

   // Advance the parse stage whenever a byte is held and the queue has room for one more word;
   // this uses registered state only, so rsp_tready never reaches req_tready.
   assign advance    = in_valid_ff && (count_ff != 2'd2);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   lpmd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .data_byte (in_byte_ff),
      .res_valid (res_valid),
      .result    (result)
   );

   assign push = advance && res_valid;
   assign pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      count_in = count_ff;
      q0_in    = q0_ff;
      q1_in    = q1_ff;
      unique case (count_ff)
         2'd0: begin
            if (push) begin
               q0_in    = result;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               q0_in = result;
            end else if (push) begin
               q1_in    = result;
               count_in = 2'd2;
            end else if (pop) begin
               count_in = 2'd0;
            end
         end
         2'd2: begin
            // no push possible while full; drop the head on pop
            if (pop) begin
               q0_in    = q1_ff;
               count_in = 2'd1;
            end
         end
         default: begin
            count_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         count_ff    <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         count_ff    <= count_in;
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
      end
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = {q0_ff.payload_byte, q0_ff.payload_length, q0_ff.part_total,
                        q0_ff.part_index, q0_ff.command, q0_ff.msg_type};
   assign rsp_tuser  = q0_ff.byte_valid;
   assign rsp_tlast  = q0_ff.last;

   // An empty message word ends the message and carries no length and no byte.
   assign empty_word_ok = rsp_tlast && (q0_ff.payload_length == 32'd0) &&
                          (q0_ff.payload_byte == 8'd0);

   `LPMD_ASSERT_ALWAYS(a_queue_bound, clock, reset, count_ff != 2'd3)
   `LPMD_ASSERT_IMPLY(a_empty_msg_form, clock, reset, rsp_tvalid && !rsp_tuser, empty_word_ok)
   `LPMD_ASSERT_IMPLY(a_full_blocks_parse, clock, reset, count_ff == 2'd2, !push)

endmodule
